>>> rtl/tti_pkg.sv
// shared types, constants and codes of the typing touchpad inhibit block
package tti_pkg;

    localparam int KEYMAP_BYTES = 32;
    localparam int WORD_W       = 64;
    localparam int KEY_WORDS    = KEYMAP_BYTES / 8;
    localparam int TIME_W       = 32;
    localparam int BUTTON_W     = 15;
    localparam int PAD_W        = 2;
    localparam int CFG_IDX_W    = 3;

    // pad off codes
    localparam logic [PAD_W-1:0] PAD_ON       = 2'd0;
    localparam logic [PAD_W-1:0] PAD_OFF      = 2'd1;
    localparam logic [PAD_W-1:0] PAD_TAPS_OFF = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MASK0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COMBOS = 3'd6;

    localparam logic [TIME_W-1:0] IDLE_RESET = 32'd2000;

    typedef struct packed {
        logic [WORD_W-1:0]   keys_word0;
        logic [WORD_W-1:0]   keys_word1;
        logic [WORD_W-1:0]   keys_word2;
        logic [WORD_W-1:0]   keys_word3;
        logic [BUTTON_W-1:0] button_bits;
        logic [TIME_W-1:0]   now_ms;
        logic [PAD_W-1:0]    pad_off_now;
    } poll_t;

    typedef struct packed {
        logic             pad_write;
        logic [PAD_W-1:0] pad_value;
        logic             typing_seen;
    } result_t;

    // what one key lane found
    typedef struct packed {
        logic new_hit;
        logic combo_hit;
    } lane_flags_t;

endpackage

>>> rtl/typing_touchpad_inhibit.sv
// top level of the typing touchpad inhibit block: config registers, key lanes, merge
//
// Takes one poll request per clock cycle while its single result register is empty or
// the waiting result is taken in the same cycle, and returns each result from that
// register in the next cycle. Four 64-key lanes compare the snapshot against their
// stored history and the key mask side by side; the merge stage ORs their findings and
// does the 33-bit idle deadline add and compare in the same cycle. There is no clearing
// pass after reset. Configuration writes take effect at once; the user must make them
// only while no poll is in flight, as the block itself does not enforce this.
module typing_touchpad_inhibit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tti_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tti_pkg::WORD_W-1:0]        cfg_data,
    input  logic                              poll_valid,
    output logic                              poll_ready,
    input  tti_pkg::poll_t                    poll,
    output logic                              result_valid,
    input  logic                              result_ready,
    output tti_pkg::result_t                  result
);

    logic [tti_pkg::WORD_W-1:0] mask_reg [tti_pkg::KEY_WORDS];
    logic [tti_pkg::WORD_W-1:0] mask_next [tti_pkg::KEY_WORDS];
    logic [tti_pkg::TIME_W-1:0] idle_reg, idle_next;
    logic                       taps_reg, taps_next;
    logic                       combos_reg, combos_next;

    logic [tti_pkg::WORD_W-1:0] keys [tti_pkg::KEY_WORDS];
    tti_pkg::lane_flags_t       flags [tti_pkg::KEY_WORDS];
    logic                       accept;

    assign accept  = poll_valid && poll_ready;
    assign keys[0] = poll.keys_word0;
    assign keys[1] = poll.keys_word1;
    assign keys[2] = poll.keys_word2;
    assign keys[3] = poll.keys_word3;

    always_comb
    begin
        for (int i = 0; i < tti_pkg::KEY_WORDS; i++)
        begin
            mask_next[i] = mask_reg[i];
        end
        idle_next   = idle_reg;
        taps_next   = taps_reg;
        combos_next = combos_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                tti_pkg::REG_MASK0:  mask_next[0] = cfg_data;
                tti_pkg::REG_MASK1:  mask_next[1] = cfg_data;
                tti_pkg::REG_MASK2:  mask_next[2] = cfg_data;
                tti_pkg::REG_MASK3:  mask_next[3] = cfg_data;
                tti_pkg::REG_IDLE:   idle_next    = cfg_data[tti_pkg::TIME_W-1:0];
                tti_pkg::REG_TAPS:   taps_next    = cfg_data[0];
                tti_pkg::REG_COMBOS: combos_next  = cfg_data[0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tti_pkg::KEY_WORDS; i++)
            begin
                mask_reg[i] <= '1;
            end
            idle_reg   <= tti_pkg::IDLE_RESET;
            taps_reg   <= 1'b0;
            combos_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < tti_pkg::KEY_WORDS; i++)
            begin
                mask_reg[i] <= mask_next[i];
            end
            idle_reg   <= idle_next;
            taps_reg   <= taps_next;
            combos_reg <= combos_next;
        end
    end

    for (genvar g = 0; g < tti_pkg::KEY_WORDS; g++)
    begin : g_lane
        tti_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .accept (accept),
            .keys   (keys[g]),
            .mask   (mask_reg[g]),
            .flags  (flags[g])
        );
    end

    tti_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .poll_valid    (poll_valid),
        .poll_ready    (poll_ready),
        .flags         (flags),
        .button_bits   (poll.button_bits),
        .now_ms        (poll.now_ms),
        .pad_off_now   (poll.pad_off_now),
        .idle_ms       (idle_reg),
        .taps_only     (taps_reg),
        .ignore_combos (combos_reg),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

endmodule

>>> rtl/tti_lane.sv
// one 64-key lane: key history word and masked press / combo detection
module tti_lane (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [tti_pkg::WORD_W-1:0]  keys,
    input  logic [tti_pkg::WORD_W-1:0]  mask,
    output tti_pkg::lane_flags_t        flags
);

    logic [tti_pkg::WORD_W-1:0] prev_reg;
    logic [tti_pkg::WORD_W-1:0] prev_next;

    always_comb
    begin
        prev_next       = accept ? keys : prev_reg;
        flags.new_hit   = |(keys & ~prev_reg & mask);
        flags.combo_hit = |(keys & ~mask);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else
        begin
            prev_reg <= prev_next;
        end
    end

endmodule

>>> rtl/tti_merge.sv
// merges lane flags, runs the idle timer and pad state, holds the result register
module tti_merge (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 poll_valid,
    output logic                                 poll_ready,
    input  tti_pkg::lane_flags_t                 flags [tti_pkg::KEY_WORDS],
    input  logic [tti_pkg::BUTTON_W-1:0]         button_bits,
    input  logic [tti_pkg::TIME_W-1:0]           now_ms,
    input  logic [tti_pkg::PAD_W-1:0]            pad_off_now,
    input  logic [tti_pkg::TIME_W-1:0]           idle_ms,
    input  logic                                 taps_only,
    input  logic                                 ignore_combos,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output tti_pkg::result_t                     result
);

    logic                        accept;
    logic                        any_new;
    logic                        any_combo;
    logic                        typing;
    logic [tti_pkg::TIME_W:0]    deadline;
    logic                        past_idle;

    logic                        primed_reg, primed_next;
    logic                        disabled_reg, disabled_next;
    logic [tti_pkg::TIME_W-1:0]  last_reg, last_next;
    logic                        valid_reg, valid_next;
    tti_pkg::result_t            result_reg, result_next;

    // result register frees up when empty or being taken
    assign poll_ready   = !valid_reg || result_ready;
    assign accept       = poll_valid && poll_ready;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        any_new   = 1'b0;
        any_combo = 1'b0;
        for (int i = 0; i < tti_pkg::KEY_WORDS; i++)
        begin
            any_new   = any_new | flags[i].new_hit;
            any_combo = any_combo | flags[i].combo_hit;
        end
        typing = any_new && !(ignore_combos && any_combo);

        last_next = last_reg;
        if (typing)
        begin
            last_next = now_ms;
        end
        if (button_bits != '0)
        begin
            last_next = '0;
        end

        // 33-bit deadline, no wrap
        deadline  = {1'b0, last_next} + {1'b0, idle_ms};
        past_idle = {1'b0, now_ms} > deadline;

        disabled_next          = disabled_reg;
        result_next.pad_write  = 1'b0;
        result_next.pad_value  = tti_pkg::PAD_ON;
        result_next.typing_seen = 1'b0;

        if (!primed_reg)
        begin
            // first poll only primes the key history
            last_next = last_reg;
        end
        else
        begin
            result_next.typing_seen = typing;
            if (past_idle)
            begin
                if (disabled_reg)
                begin
                    disabled_next         = 1'b0;
                    result_next.pad_write = 1'b1;
                    result_next.pad_value = tti_pkg::PAD_ON;
                end
            end
            else if (!disabled_reg && pad_off_now == tti_pkg::PAD_ON)
            begin
                disabled_next         = 1'b1;
                result_next.pad_write = 1'b1;
                result_next.pad_value = taps_only ? tti_pkg::PAD_TAPS_OFF : tti_pkg::PAD_OFF;
            end
        end

        primed_next = 1'b1;
        valid_next  = accept ? 1'b1 : (valid_reg && !result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg   <= 1'b0;
            disabled_reg <= 1'b0;
            last_reg     <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                primed_reg   <= primed_next;
                disabled_reg <= disabled_next;
                last_reg     <= last_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

endmodule
